### design/chct_pkg.sv
// Shared constants and types for the canonical Huffman code table.
`timescale 1ns / 1ps

package chct_pkg;

    // Fixed field widths of the ports.
    localparam int SYM_W  = 9;
    localparam int LEN_W  = 4;
    localparam int CODE_W = 15;

    // Longest code length that may be stored; longer lengths are stored as unused.
    localparam int MAX_CODE_BITS = 15;

    localparam int DEFAULT_MAX_SYMBOLS = 288;
    localparam logic [SYM_W-1:0] SYMBOL_COUNT_RESET = SYM_W'(288);

    // Command codes of an input word.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TARGET,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

### design/canonical_huffman_code_table.sv
// Canonical Huffman code table: length store, rank-and-sum sequencer, output register.
`timescale 1ns / 1ps

// Holds one code length per symbol and answers the DEFLATE canonical code of a symbol.
// After reset the length store is cleared one entry per cycle; no word is taken during
// that pass, configuration writes are. A write word goes straight into the length store.
// For a read word one memory read fetches the symbol's own length, then the sequencer
// walks every active entry of the length memory, one per cycle (an absent symbol skips
// the walk); a single adder accumulates either the weight 2^(L-l) of a shorter code or
// one for an earlier symbol of the same length L. The result waits in an output register,
// so the next word is accepted while the result is still held.
module canonical_huffman_code_table #(
    parameter int MAX_SYMBOLS = chct_pkg::DEFAULT_MAX_SYMBOLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [chct_pkg::SYM_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [chct_pkg::SYM_W-1:0]     symbol,
    input  logic [chct_pkg::LEN_W-1:0]     length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [chct_pkg::SYM_W-1:0]     symbol_out,
    output logic [chct_pkg::CODE_W-1:0]    code,
    output logic [chct_pkg::LEN_W-1:0]     code_len,
    output logic                           present
);

    localparam int SYM_W  = chct_pkg::SYM_W;
    localparam int LEN_W  = chct_pkg::LEN_W;
    localparam int CODE_W = chct_pkg::CODE_W;
    localparam int ADDR_W = $clog2(MAX_SYMBOLS);
    localparam int N_W    = $clog2(MAX_SYMBOLS + 1);
    localparam int EXT_W  = SYM_W + 1;

    chct_pkg::state_t state_reg, state_next;

    logic [SYM_W-1:0]  symbol_count_reg;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic              out_valid_reg, out_valid_next;

    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [LEN_W-1:0]  target_len_reg, target_len_next;
    logic [ADDR_W-1:0] walk_idx_reg, walk_idx_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic              hit_reg, hit_next;

    logic [SYM_W-1:0]  symbol_out_reg, symbol_out_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  code_len_reg, code_len_next;
    logic              present_reg, present_next;

    // Length memory, one write and one registered read per cycle.
    logic [LEN_W-1:0]  len_mem [MAX_SYMBOLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LEN_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [LEN_W-1:0]  rd_data_reg;

    logic [EXT_W-1:0]  count_ext;
    logic [EXT_W-1:0]  max_ext;
    logic [N_W-1:0]    eff_count;
    logic [LEN_W-1:0]  clamped_len;
    logic [LEN_W-1:0]  shift_amt;
    logic [CODE_W-1:0] term;
    logic [CODE_W:0]   mask_wide;
    logic              out_free;
    logic              last_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            len_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= len_mem[mem_raddr];
    end

    always_comb
    begin
        count_ext   = EXT_W'(symbol_count_reg);
        max_ext     = EXT_W'(MAX_SYMBOLS);
        eff_count   = N_W'((count_ext < max_ext) ? count_ext : max_ext);
        clamped_len = ({1'b0, length} > 5'(chct_pkg::MAX_CODE_BITS)) ? '0 : length;
        out_free    = !out_valid_reg || out_ready;
        last_entry  = (EXT_W'(walk_idx_reg) + EXT_W'(1)) == EXT_W'(eff_count);
        shift_amt   = target_len_reg - rd_data_reg;
        mask_wide   = ((CODE_W + 1)'(1) << target_len_reg) - (CODE_W + 1)'(1);

        // A shorter code adds its weight toward the first code of the target length;
        // an earlier symbol of the same length adds one to the rank.
        if ((rd_data_reg != '0) && (rd_data_reg < target_len_reg))
        begin
            term = CODE_W'(1) << shift_amt;
        end
        else if ((rd_data_reg == target_len_reg) &&
                 (EXT_W'(walk_idx_reg) < EXT_W'(sym_reg)))
        begin
            term = CODE_W'(1);
        end
        else
        begin
            term = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= chct_pkg::ST_CLEAR;
            clr_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
            symbol_count_reg <= chct_pkg::SYMBOL_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                symbol_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        target_len_reg  <= target_len_next;
        walk_idx_reg    <= walk_idx_next;
        acc_reg         <= acc_next;
        hit_reg         <= hit_next;
        symbol_out_reg  <= symbol_out_next;
        code_reg        <= code_next;
        code_len_reg    <= code_len_next;
        present_reg     <= present_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        sym_next         = sym_reg;
        target_len_next  = target_len_reg;
        walk_idx_next    = walk_idx_reg;
        acc_next         = acc_reg;
        hit_next         = hit_reg;
        symbol_out_next  = symbol_out_reg;
        code_next        = code_reg;
        code_len_next    = code_len_reg;
        present_next     = present_reg;
        in_ready         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = clr_idx_reg;
        mem_wdata        = '0;
        mem_raddr        = walk_idx_reg + ADDR_W'(1);

        unique case (state_reg)
            chct_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_idx_reg == ADDR_W'(MAX_SYMBOLS - 1))
                begin
                    state_next = chct_pkg::ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + ADDR_W'(1);
                end
            end

            chct_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_waddr = symbol[ADDR_W-1:0];
                mem_wdata = clamped_len;
                mem_raddr = symbol[ADDR_W-1:0];
                if (in_valid)
                begin
                    if (cmd == chct_pkg::CMD_WRITE)
                    begin
                        mem_we = EXT_W'(symbol) < max_ext;
                    end
                    else
                    begin
                        sym_next   = symbol;
                        state_next = chct_pkg::ST_TARGET;
                    end
                end
            end

            chct_pkg::ST_TARGET:
            begin
                // The symbol's own length is in the read register now.
                mem_raddr       = '0;
                target_len_next = rd_data_reg;
                walk_idx_next   = '0;
                acc_next        = '0;
                if ((EXT_W'(sym_reg) >= EXT_W'(eff_count)) || (rd_data_reg == '0))
                begin
                    hit_next   = 1'b0;
                    state_next = chct_pkg::ST_FINISH;
                end
                else
                begin
                    hit_next   = 1'b1;
                    state_next = chct_pkg::ST_WALK;
                end
            end

            chct_pkg::ST_WALK:
            begin
                acc_next = acc_reg + term;
                if (last_entry)
                begin
                    state_next = chct_pkg::ST_FINISH;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + ADDR_W'(1);
                end
            end

            chct_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    symbol_out_next  = sym_reg;
                    code_next        = hit_reg ? (acc_reg & mask_wide[CODE_W-1:0]) : '0;
                    code_len_next    = hit_reg ? target_len_reg : '0;
                    present_next     = hit_reg;
                    state_next       = chct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = chct_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign symbol_out  = symbol_out_reg;
    assign code        = code_reg;
    assign code_len    = code_len_reg;
    assign present     = present_reg;

endmodule

### test/code_table_checker.sv
// Checker for the canonical Huffman code table: predicts each code word and compares results.
`timescale 1ns / 1ps

module code_table_checker #(
    parameter int MAX_SYMBOLS = chct_pkg::DEFAULT_MAX_SYMBOLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [chct_pkg::SYM_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        cmd,
    input  logic [chct_pkg::SYM_W-1:0]  symbol,
    input  logic [chct_pkg::LEN_W-1:0]  length,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [chct_pkg::SYM_W-1:0]  symbol_out,
    input  logic [chct_pkg::CODE_W-1:0] code,
    input  logic [chct_pkg::LEN_W-1:0]  code_len,
    input  logic                        present,
    output int                          expected_left,
    output int                          mismatches
);

    typedef struct packed {
        logic [chct_pkg::SYM_W-1:0]  sym;
        logic [chct_pkg::CODE_W-1:0] code;
        logic [chct_pkg::LEN_W-1:0]  len;
        logic                        present;
    } code_word_t;

    logic [chct_pkg::LEN_W-1:0] length_copy [MAX_SYMBOLS];
    logic [chct_pkg::SYM_W-1:0] count_copy;
    code_word_t                 expected_codes [$];

    function automatic code_word_t canonical_code(input logic [chct_pkg::SYM_W-1:0] sym);
        code_word_t                 r;
        logic [chct_pkg::SYM_W-1:0] tally [16];
        int unsigned                n;
        int unsigned                l;
        int unsigned                first;
        int unsigned                below;
        int unsigned                rank;
        int unsigned                sum;
        r.sym     = sym;
        r.code    = '0;
        r.len     = '0;
        r.present = 1'b0;
        n = (int'(count_copy) < MAX_SYMBOLS) ? int'(count_copy) : MAX_SYMBOLS;
        if (int'(sym) >= n)
            return r;
        l = length_copy[sym];
        if (l == 0)
            return r;
        for (int i = 0; i < 16; i++)
            tally[i] = '0;
        for (int i = 0; i < n; i++)
            if (length_copy[i] != '0)
                tally[length_copy[i]] = tally[length_copy[i]] + 1'b1;
        // First code of each length: add the count of the length below, then shift left.
        first = 0;
        for (int b = 1; b <= l; b++)
        begin
            below = (b == 1) ? 0 : tally[b-1];
            first = ((first + below) << 1) & 32'h00FF_FFFF;
        end
        rank = 0;
        for (int j = 0; j < int'(sym); j++)
            if (length_copy[j] == chct_pkg::LEN_W'(l))
                rank++;
        // Over-subscribed sets wrap within the code length.
        sum       = (first + rank) & ((32'd1 << l) - 1);
        r.code    = chct_pkg::CODE_W'(sum);
        r.len     = chct_pkg::LEN_W'(l);
        r.present = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        code_word_t want;
        code_word_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
                length_copy[i] = '0;
            count_copy = chct_pkg::SYMBOL_COUNT_RESET;
            expected_codes.delete();
            mismatches = 0;
            expected_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.sym     = symbol_out;
                got.code    = code;
                got.len     = code_len;
                got.present = present;
                if (expected_codes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result word for symbol %0d with nothing expected",
                                 $time, got.sym);
                    mismatches++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.sym != want.sym || got.code != want.code
                            || got.len != want.len || got.present != want.present)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch: got symbol %0d code %h len %0d present %0d",
                                     $time, got.sym, got.code, got.len, got.present);
                            $display("%0t:   expected symbol %0d code %h len %0d present %0d",
                                     $time, want.sym, want.code, want.len, want.present);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == chct_pkg::CMD_READ)
                    expected_codes.push_back(canonical_code(symbol));
                else if (int'(symbol) < MAX_SYMBOLS)
                    length_copy[symbol] =
                        (int'(length) > chct_pkg::MAX_CODE_BITS) ? '0 : length;
            end
            if (cfg_wr_en)
                count_copy = cfg_wr_data;
            expected_left <= expected_codes.size();
        end
    end

endmodule

### test/tb_canonical_huffman_code_table.sv
// Testbench top for the canonical Huffman code table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_canonical_huffman_code_table;

    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_WORDS     = 100;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [chct_pkg::SYM_W-1:0]  cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic                        cmd         = chct_pkg::CMD_WRITE;
    logic [chct_pkg::SYM_W-1:0]  symbol      = '0;
    logic [chct_pkg::LEN_W-1:0]  length      = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [chct_pkg::SYM_W-1:0]  symbol_out;
    logic [chct_pkg::CODE_W-1:0] code;
    logic [chct_pkg::LEN_W-1:0]  code_len;
    logic                        present;

    int   expected_left;
    int   mismatches;
    int   quiet_cycles = 0;
    int   phase_words  = 0;
    int   active_count = chct_pkg::DEFAULT_MAX_SYMBOLS;
    logic calm         = 1'b0;
    logic hold_off_go  = 1'b0;

    canonical_huffman_code_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .symbol      (symbol),
        .length      (length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol_out  (symbol_out),
        .code        (code),
        .code_len    (code_len),
        .present     (present)
    );

    code_table_checker u_code_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .symbol        (symbol),
        .length        (length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol_out    (symbol_out),
        .code          (code),
        .code_len      (code_len),
        .present       (present),
        .expected_left (expected_left),
        .mismatches    (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run ends if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** canonical_huffman_code_table: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls, one long hold-off on request, none while calm.
    initial
    begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 8);
        end
    end

    function automatic int eff_count();
        return (active_count < chct_pkg::DEFAULT_MAX_SYMBOLS) ?
               active_count : chct_pkg::DEFAULT_MAX_SYMBOLS;
    endfunction

    task automatic send_word(input logic c, input logic [chct_pkg::SYM_W-1:0] s,
                             input logic [chct_pkg::LEN_W-1:0] l);
        if (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        symbol   <= s;
        length   <= l;
        do
            @(posedge clk);
        while (!in_ready);
        phase_words++;
    endtask

    // Stop offering words until every result is back and a trailing write has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic start_phase(input int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= chct_pkg::SYM_W'(value);
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        active_count = value;
        phase_words  = 0;
    endtask

    // Writes a complete prefix code over k neighboring symbols, then reads k random symbols of the set back.
    task automatic load_code_set(input int base, input int k);
        int lens[$];
        int pick;
        int j;
        int t;
        lens = {1, 1};
        while (lens.size() < k)
        begin
            pick = $urandom_range(lens.size() - 1);
            if (lens[pick] < chct_pkg::MAX_CODE_BITS)
            begin
                lens[pick]++;
                lens.push_back(lens[pick]);
            end
        end
        for (int i = k - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            t       = lens[i];
            lens[i] = lens[j];
            lens[j] = t;
        end
        for (int i = 0; i < k; i++)
            send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(base + i),
                      chct_pkg::LEN_W'(lens[i]));
        for (int i = 0; i < k; i++)
            send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(base + $urandom_range(k - 1)),
                      chct_pkg::LEN_W'($urandom_range(15)));
    endtask

    task automatic noise_word();
        logic [chct_pkg::SYM_W-1:0] s;
        logic [chct_pkg::LEN_W-1:0] l;
        if ($urandom_range(99) < 15)
            s = chct_pkg::SYM_W'($urandom_range(511));
        else
            s = chct_pkg::SYM_W'($urandom_range(eff_count() + 1));
        l = ($urandom_range(99) < 30) ? '0 : chct_pkg::LEN_W'($urandom_range(15));
        send_word(($urandom_range(1) == 1) ? chct_pkg::CMD_READ : chct_pkg::CMD_WRITE, s, l);
    endtask

    task automatic fill_phase(input int budget);
        int e;
        int k;
        while (phase_words < budget)
        begin
            e = eff_count();
            if (e >= 2 && $urandom_range(99) < 60)
            begin
                k = $urandom_range(2, (e < 40) ? e : 40);
                load_code_set($urandom_range(e - k), k);
            end
            else
                noise_word();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store right after reset, then extremes of symbol and length.
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(0), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(0), chct_pkg::LEN_W'(15));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(1), chct_pkg::LEN_W'(15));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(287), chct_pkg::LEN_W'(1));
        // Writes past the end of the store are dropped.
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(288), chct_pkg::LEN_W'(3));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(511), chct_pkg::LEN_W'(7));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(5), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(0), chct_pkg::LEN_W'(15));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(1), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(287), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(288), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(511), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(5), chct_pkg::LEN_W'(0));
        // Three codes of length one overflow the code space and wrap.
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(2), chct_pkg::LEN_W'(1));
        send_word(chct_pkg::CMD_WRITE, chct_pkg::SYM_W'(3), chct_pkg::LEN_W'(1));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(3), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(287), chct_pkg::LEN_W'(0));
        // A symbol count of zero hides everything; one above the store is clipped.
        start_phase(0);
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(0), chct_pkg::LEN_W'(0));
        start_phase(511);
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(287), chct_pkg::LEN_W'(0));
        start_phase(1);
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(0), chct_pkg::LEN_W'(0));
        send_word(chct_pkg::CMD_READ, chct_pkg::SYM_W'(1), chct_pkg::LEN_W'(0));

        start_phase(288);
        fill_phase(PHASE_WORDS);
        // The long result stall comes while words keep arriving.
        start_phase(19);
        hold_off_go <= 1'b1;
        fill_phase(PHASE_WORDS);
        start_phase(1);
        fill_phase(PHASE_WORDS);
        start_phase(511);
        fill_phase(PHASE_WORDS);
        start_phase(30);
        calm <= 1'b1;
        fill_phase(PHASE_WORDS);
        calm <= 1'b0;
        start_phase(144);
        fill_phase(PHASE_WORDS);
        start_phase(289);
        fill_phase(PHASE_WORDS);
        start_phase(0);
        fill_phase(PHASE_WORDS);
        start_phase($urandom_range(2, 287));
        fill_phase(PHASE_WORDS);
        start_phase($urandom_range(2, 60));
        fill_phase(PHASE_WORDS);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("** canonical_huffman_code_table: PASSED **");
        else
            $display("** canonical_huffman_code_table: FAILED **");
        $finish;
    end

endmodule
